@@ sv/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained hash map package
// Payload types, status and operation codes, and sequencer states.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int PAYLOAD_BITS = 32;
    localparam int COUNT_BITS   = 9;

    typedef logic [2:0] t_op;
    localparam t_op OP_INSERT   = 3'd0;
    localparam t_op OP_REMOVE   = 3'd1;
    localparam t_op OP_CONTAINS = 3'd2;
    localparam t_op OP_GET      = 3'd3;
    localparam t_op OP_SET      = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_op                     operation;
        logic [PAYLOAD_BITS-1:0] key_in;
        logic [PAYLOAD_BITS-1:0] key_hash;
        logic [PAYLOAD_BITS-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic [PAYLOAD_BITS-1:0] key_out;
        logic [PAYLOAD_BITS-1:0] value_out;
        logic [COUNT_BITS-1:0]   entry_count;
    } t_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_WALK,
        S_CMP,
        S_DECIDE,
        S_INS_A,
        S_INS_B,
        S_REM_A,
        S_REM_B,
        S_REM_C,
        S_REM_D,
        S_REM_E,
        S_SET,
        S_RESP
    } t_state;

endpackage

@@ sv/chm_if.sv @@
// ----------------------------------------------------------------------------
// Chained hash map stream interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface chm_req_if;
    logic          valid;
    logic          ready;
    chm_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface chm_rsp_if;
    logic          valid;
    logic          ready;
    chm_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ sv/chained_hash_map_engine_top.sv @@
// ----------------------------------------------------------------------------
// Chained hash map engine
// Key-value map with per-bucket doubly linked chains over dense entry RAMs.
// ----------------------------------------------------------------------------
// A request is answered after the bucket index is found and the chain is walked to a hit
// or to its end; the bucket unit is a registered slice for a power-of-two bucket count,
// else a serial divider. Insert, set and remove then write the RAMs; a remove that does
// not free the last slot also moves that slot into the hole. An unknown operation skips the walk.
// Throughput: one operation at a time; the chain walk through registered-read RAMs sets the
// rate. After reset the bucket heads are cleared, with no request accepted.
module chained_hash_map_engine_top #(
    parameter int ENTRIES    = 256,
    parameter int BUCKETS    = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    chm_req_if.sink   i_req,
    chm_rsp_if.source o_rsp
);

    // Link fields hold a slot index or the empty marker, which equals ENTRIES.
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int AW = $clog2(ENTRIES);
    localparam int BW = $clog2(BUCKETS);
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam logic [LW-1:0] EMPTY = LW'(ENTRIES);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

    chm_pkg::t_state r_state, n_state;

    // Request registers.
    chm_pkg::t_op   r_op;
    logic [KW-1:0]  r_key;
    logic [31:0]    r_hash;
    logic [VW-1:0]  r_value;

    // Walk and entry registers.
    logic [LW-1:0]  r_count;
    logic [LW-1:0]  r_last;
    logic [LW-1:0]  r_head;
    logic [LW-1:0]  r_node;
    logic [LW-1:0]  r_steps;
    logic           r_found;
    logic [AW-1:0]  r_slot;
    logic [LW-1:0]  r_enext;
    logic [LW-1:0]  r_eprev;
    logic [LW-1:0]  r_p2;
    logic [LW-1:0]  r_n2;
    logic [BW-1:0]  r_clr;

    // Result registers.
    chm_pkg::t_status r_status;
    logic [KW-1:0]    r_okey;
    logic [VW-1:0]    r_oval;

    // Memory ports.
    logic           head_we,  next_we,  prev_we,  hash_we,  key_we,  val_we;
    logic [BW-1:0]  head_waddr;
    logic [AW-1:0]  next_waddr, prev_waddr, ent_waddr;
    logic [LW-1:0]  head_wdata, next_wdata, prev_wdata;
    logic [31:0]    hash_wdata;
    logic [KW-1:0]  key_wdata;
    logic [VW-1:0]  val_wdata;
    logic [AW-1:0]  ent_raddr;
    logic [LW-1:0]  head_rd, next_rd, prev_rd;
    logic [31:0]    hash_rd;
    logic [KW-1:0]  key_rd;
    logic [VW-1:0]  val_rd;

    // Bucket unit.
    logic           bkt_start;
    logic [31:0]    bkt_hash;
    logic           bkt_done;
    logic [BW-1:0]  bkt_index;

    logic req_xfer;
    logic rsp_xfer;
    logic match;

    assign req_xfer = i_req.valid && i_req.ready;
    assign rsp_xfer = o_rsp.valid && o_rsp.ready;
    assign match    = (hash_rd == r_hash) && (key_rd == r_key);

    assign i_req.ready = (r_state == chm_pkg::S_IDLE);
    assign o_rsp.valid = (r_state == chm_pkg::S_RESP);
    assign o_rsp.payload.status      = r_status;
    assign o_rsp.payload.key_out     = 32'(r_okey);
    assign o_rsp.payload.value_out   = 32'(r_oval);
    assign o_rsp.payload.entry_count = chm_pkg::COUNT_BITS'(r_count);

    // The bucket index is computed once for the request and again for the
    // hash of the slot that is moved into the hole on a remove.
    assign bkt_start = req_xfer || (r_state == chm_pkg::S_REM_C);
    assign bkt_hash  = (r_state == chm_pkg::S_REM_C) ? hash_rd : i_req.payload.key_hash;

    chm_bucket #(.BUCKETS(BUCKETS)) u_bucket (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (bkt_start),
        .i_hash   (bkt_hash),
        .o_done   (bkt_done),
        .o_bucket (bkt_index)
    );

    chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
        .i_clk (i_clk), .i_we (head_we), .i_waddr (head_waddr), .i_wdata (head_wdata),
        .i_raddr (bkt_index), .o_rdata (head_rd)
    );
    chm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
        .i_clk (i_clk), .i_we (next_we), .i_waddr (next_waddr), .i_wdata (next_wdata),
        .i_raddr (ent_raddr), .o_rdata (next_rd)
    );
    chm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_prev (
        .i_clk (i_clk), .i_we (prev_we), .i_waddr (prev_waddr), .i_wdata (prev_wdata),
        .i_raddr (ent_raddr), .o_rdata (prev_rd)
    );
    chm_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_hash (
        .i_clk (i_clk), .i_we (hash_we), .i_waddr (ent_waddr), .i_wdata (hash_wdata),
        .i_raddr (ent_raddr), .o_rdata (hash_rd)
    );
    chm_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key (
        .i_clk (i_clk), .i_we (key_we), .i_waddr (ent_waddr), .i_wdata (key_wdata),
        .i_raddr (ent_raddr), .o_rdata (key_rd)
    );
    chm_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_value (
        .i_clk (i_clk), .i_we (val_we), .i_waddr (ent_waddr), .i_wdata (val_wdata),
        .i_raddr (ent_raddr), .o_rdata (val_rd)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            chm_pkg::S_CLEAR: begin
                if (r_clr == LAST_BUCKET) n_state = chm_pkg::S_IDLE;
            end
            chm_pkg::S_IDLE: begin
                if (req_xfer) begin
                    n_state = (i_req.payload.operation > chm_pkg::OP_SET) ?
                              chm_pkg::S_RESP : chm_pkg::S_HASH;
                end
            end
            chm_pkg::S_HASH: begin
                if (bkt_done) n_state = chm_pkg::S_HEAD;
            end
            chm_pkg::S_HEAD: n_state = chm_pkg::S_WALK;
            chm_pkg::S_WALK: begin
                n_state = (r_node < r_count && r_steps < EMPTY) ?
                          chm_pkg::S_CMP : chm_pkg::S_DECIDE;
            end
            chm_pkg::S_CMP: n_state = match ? chm_pkg::S_DECIDE : chm_pkg::S_WALK;
            chm_pkg::S_DECIDE: begin
                case (r_op)
                    chm_pkg::OP_INSERT: begin
                        n_state = (r_found || r_count == EMPTY) ?
                                  chm_pkg::S_RESP : chm_pkg::S_INS_A;
                    end
                    chm_pkg::OP_REMOVE: n_state = r_found ? chm_pkg::S_REM_A : chm_pkg::S_RESP;
                    chm_pkg::OP_SET:    n_state = r_found ? chm_pkg::S_SET : chm_pkg::S_RESP;
                    default:            n_state = chm_pkg::S_RESP;
                endcase
            end
            chm_pkg::S_INS_A: n_state = chm_pkg::S_INS_B;
            chm_pkg::S_INS_B: n_state = chm_pkg::S_RESP;
            chm_pkg::S_REM_A: begin
                n_state = (LW'(r_slot) == r_last) ? chm_pkg::S_RESP : chm_pkg::S_REM_B;
            end
            chm_pkg::S_REM_B: n_state = chm_pkg::S_REM_C;
            chm_pkg::S_REM_C: n_state = chm_pkg::S_REM_D;
            chm_pkg::S_REM_D: begin
                if (bkt_done) n_state = chm_pkg::S_REM_E;
            end
            chm_pkg::S_REM_E: n_state = chm_pkg::S_RESP;
            chm_pkg::S_SET:   n_state = chm_pkg::S_RESP;
            chm_pkg::S_RESP: begin
                if (rsp_xfer) n_state = chm_pkg::S_IDLE;
            end
            default: n_state = chm_pkg::S_IDLE;
        endcase
    end

    // Memory controls for each step of the sequence.
    always_comb begin
        head_we    = 1'b0;
        head_waddr = bkt_index;
        head_wdata = EMPTY;
        next_we    = 1'b0;
        next_waddr = r_slot;
        next_wdata = r_enext;
        prev_we    = 1'b0;
        prev_waddr = r_slot;
        prev_wdata = r_eprev;
        hash_we    = 1'b0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        ent_waddr  = r_slot;
        hash_wdata = r_hash;
        key_wdata  = r_key;
        val_wdata  = r_value;
        ent_raddr  = r_node[AW-1:0];
        case (r_state)
            chm_pkg::S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
            end
            chm_pkg::S_INS_A: begin
                // New slot goes to the head of its chain.
                prev_we    = (r_head < EMPTY);
                prev_waddr = r_head[AW-1:0];
                prev_wdata = r_count;
                next_we    = 1'b1;
                next_waddr = r_count[AW-1:0];
                next_wdata = r_head;
                head_we    = 1'b1;
                head_wdata = r_count;
                hash_we    = 1'b1;
                key_we     = 1'b1;
                val_we     = 1'b1;
                ent_waddr  = r_count[AW-1:0];
            end
            chm_pkg::S_INS_B: begin
                prev_we    = 1'b1;
                prev_waddr = r_count[AW-1:0];
                prev_wdata = EMPTY;
            end
            chm_pkg::S_REM_A: begin
                // Unlink the removed slot from its chain.
                next_we    = (r_eprev < EMPTY);
                next_waddr = r_eprev[AW-1:0];
                next_wdata = r_enext;
                head_we    = !(r_eprev < EMPTY);
                head_wdata = r_enext;
                prev_we    = (r_enext < EMPTY);
                prev_waddr = r_enext[AW-1:0];
                prev_wdata = r_eprev;
            end
            chm_pkg::S_REM_B: begin
                ent_raddr = r_last[AW-1:0];
            end
            chm_pkg::S_REM_C: begin
                // Copy the last slot into the hole.
                hash_we    = 1'b1;
                key_we     = 1'b1;
                val_we     = 1'b1;
                hash_wdata = hash_rd;
                key_wdata  = key_rd;
                val_wdata  = val_rd;
                next_we    = 1'b1;
                next_wdata = next_rd;
                prev_we    = 1'b1;
                prev_wdata = prev_rd;
            end
            chm_pkg::S_REM_E: begin
                // Point the moved slot's neighbors and bucket at its new place.
                next_we    = (r_p2 < EMPTY);
                next_waddr = r_p2[AW-1:0];
                next_wdata = LW'(r_slot);
                head_we    = !(r_p2 < EMPTY);
                head_wdata = LW'(r_slot);
                prev_we    = (r_n2 < EMPTY);
                prev_waddr = r_n2[AW-1:0];
                prev_wdata = LW'(r_slot);
            end
            chm_pkg::S_SET: begin
                val_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == chm_pkg::S_CLEAR) begin
                r_clr <= r_clr + BW'(1);
            end
            if (r_state == chm_pkg::S_INS_B) begin
                r_count <= r_count + LW'(1);
            end
            if ((r_state == chm_pkg::S_REM_A && LW'(r_slot) == r_last) ||
                r_state == chm_pkg::S_REM_E) begin
                r_count <= r_last;
            end
        end

        case (r_state)
            chm_pkg::S_IDLE: begin
                if (req_xfer) begin
                    r_op     <= i_req.payload.operation;
                    r_key    <= i_req.payload.key_in[KW-1:0];
                    r_hash   <= i_req.payload.key_hash;
                    r_value  <= i_req.payload.value_in[VW-1:0];
                    r_status <= chm_pkg::ST_NOT_FOUND;
                    r_okey   <= '0;
                    r_oval   <= '0;
                end
            end
            chm_pkg::S_HEAD: begin
                r_node  <= head_rd;
                r_head  <= head_rd;
                r_steps <= '0;
                r_found <= 1'b0;
                r_last  <= r_count - LW'(1);
            end
            chm_pkg::S_CMP: begin
                if (match) begin
                    r_found <= 1'b1;
                    r_slot  <= r_node[AW-1:0];
                    r_enext <= next_rd;
                    r_eprev <= prev_rd;
                    r_okey  <= (r_op == chm_pkg::OP_REMOVE) ? key_rd : '0;
                    r_oval  <= (r_op == chm_pkg::OP_REMOVE || r_op == chm_pkg::OP_GET ||
                                r_op == chm_pkg::OP_SET) ? val_rd : '0;
                end else begin
                    r_node  <= next_rd;
                    r_steps <= r_steps + LW'(1);
                end
            end
            chm_pkg::S_DECIDE: begin
                if (r_op == chm_pkg::OP_INSERT) begin
                    if (r_found) begin
                        r_status <= chm_pkg::ST_DUPLICATE;
                    end else if (r_count == EMPTY) begin
                        r_status <= chm_pkg::ST_FULL;
                    end else begin
                        r_status <= chm_pkg::ST_OK;
                    end
                end else if (r_found) begin
                    r_status <= chm_pkg::ST_OK;
                end
            end
            chm_pkg::S_REM_C: begin
                r_p2 <= prev_rd;
                r_n2 <= next_rd;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ sv/chm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/chm_bucket.sv @@
// ----------------------------------------------------------------------------
// Bucket index unit
// Reduces a 32-bit hash modulo the bucket count: a bit slice for a power-of-two count, else four bits per cycle.
// ----------------------------------------------------------------------------
module chm_bucket #(
    parameter int BUCKETS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_hash,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);

    localparam int  BW   = $clog2(BUCKETS);
    localparam bit  POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    generate
        if (POW2) begin : g_pow2
            logic          r_done;
            logic [BW-1:0] r_bucket;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_bucket <= i_hash[BW-1:0];
                end
            end

            assign o_done   = r_done;
            assign o_bucket = r_bucket;
        end else begin : g_div
            localparam logic [BW:0] MODULUS = (BW + 1)'(BUCKETS);

            logic        r_busy;
            logic        r_done;
            logic [2:0]  r_cnt;
            logic [31:0] r_sh;
            logic [BW:0] r_rem;
            logic [BW:0] n_rem;

            // Restoring reduction: shift in one hash bit, subtract once if needed.
            always_comb begin
                logic [BW:0] t;
                t = r_rem;
                for (int k = 0; k < 4; k++) begin
                    t = {t[BW-1:0], r_sh[31-k]};
                    if (t >= MODULUS) begin
                        t = t - MODULUS;
                    end
                end
                n_rem = t;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else if (i_start) begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else if (r_busy) begin
                    r_cnt  <= r_cnt + 3'd1;
                    r_done <= (r_cnt == 3'd7);
                    r_busy <= (r_cnt != 3'd7);
                end else begin
                    r_done <= 1'b0;
                end
                if (i_start) begin
                    r_sh  <= i_hash;
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_sh  <= {r_sh[27:0], 4'd0};
                    r_rem <= n_rem;
                end
            end

            assign o_done   = r_done;
            assign o_bucket = r_rem[BW-1:0];
        end
    endgenerate

endmodule
